[hw/rtl/roulette_wheel_selector_top_defines.svh]
// Assertion macros for the roulette wheel selector.
`ifndef ROULETTE_WHEEL_SELECTOR_TOP_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define RWS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define RWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rws_pkg.sv]
package rws_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int FITNESS_BITS = 16;

    localparam int OP_W      = 2;
    localparam int FIT_IN_W  = 16;
    localparam int FRAC_W    = 16;
    localparam int INDEX_W   = 8;
    localparam int STATUS_W  = 2;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = FITNESS_BITS + IDX_W;
    localparam int TGT_W = SUM_W + FRAC_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_DRAW  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

[hw/rtl/roulette_wheel_selector_top.sv]
// Roulette wheel selector. Each input transaction gives exactly one result
// transaction. A load (op 0) appends a fitness and stores the running sum in
// a 256 x 24 table; a full table drops the load with status 1. A clear (op 2)
// empties the table; op 3 does nothing. Each of these results is registered,
// in the output register the cycle after the input transaction. A draw (op 1)
// returns the first index i whose cumulative sum satisfies
// sum_i * 65536 >= r * total, ties to the lowest index, or status 2 on an
// empty or zero-sum table. Its length is set by the binary search over the
// table RAM (one write port, one read port): r * total is registered with the
// input transaction, state S_ISSUE issues the first table read, then state
// S_CMP compares each read word and issues the next dependent read, up to
// ceil(log2(entries)) reads, until the search range holds one index and the
// result goes to the output register.
// Input transactions are taken only while no draw is in progress and the
// output register is empty or draining.
module roulette_wheel_selector_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rws_pkg::OP_W-1:0]     op,
    input  logic [rws_pkg::FIT_IN_W-1:0] fitness,
    input  logic [rws_pkg::FRAC_W-1:0]   random_fraction,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rws_pkg::INDEX_W-1:0]  selected_index,
    output logic [rws_pkg::STATUS_W-1:0] status
);

    import rws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_CMP
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]   total_reg;
    logic [TGT_W-1:0]   target_reg;
    logic [IDX_W-1:0]   lo_reg;
    logic [IDX_W-1:0]   hi_reg;
    logic [IDX_W-1:0]   mid_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] selected_index_reg;
    logic [STATUS_W-1:0] status_reg;

    logic               out_free;
    logic               accept;
    logic               full;
    logic [SUM_W-1:0]   fit_ext;
    logic [SUM_W-1:0]   load_sum;
    logic [IDX_W-1:0]   mid_issue;
    logic               cmp_ge;
    logic [IDX_W-1:0]   lo_next;
    logic [IDX_W-1:0]   hi_next;
    logic [IDX_W-1:0]   mid_next;

    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [SUM_W-1:0]   ram_rdata;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign fit_ext  = SUM_W'(fitness[FITNESS_BITS-1:0]);
    assign load_sum = total_reg + fit_ext;
    assign ram_we   = accept && (op == OP_LOAD) && !full;

    assign mid_issue = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cmp_ge    = {ram_rdata, FRAC_W'(0)} >= target_reg;
    assign lo_next   = cmp_ge ? lo_reg : mid_reg + IDX_W'(1);
    assign hi_next   = cmp_ge ? mid_reg : hi_reg;
    assign mid_next  = lo_next + ((hi_next - lo_next) >> 1);

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = mid_issue;
        if (state_reg == S_ISSUE)
        begin
            ram_re    = lo_reg < hi_reg;
            ram_raddr = mid_issue;
        end
        else if (state_reg == S_CMP)
        begin
            ram_re    = lo_next < hi_next;
            ram_raddr = mid_next;
        end
    end

    rws_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (load_sum),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            count_reg          <= '0;
            total_reg          <= '0;
            target_reg         <= '0;
            lo_reg             <= '0;
            hi_reg             <= '0;
            mid_reg            <= '0;
            out_valid_reg      <= 1'b0;
            selected_index_reg <= '0;
            status_reg         <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (op)
                            OP_LOAD:
                            begin
                                selected_index_reg <= '0;
                                out_valid_reg      <= 1'b1;
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    total_reg  <= load_sum;
                                    count_reg  <= count_reg + CNT_W'(1);
                                end
                            end
                            OP_DRAW:
                            begin
                                selected_index_reg <= '0;
                                if (count_reg == '0 || total_reg == '0)
                                begin
                                    status_reg    <= ST_EMPTY;
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    status_reg    <= ST_OK;
                                    out_valid_reg <= 1'b0;
                                    target_reg    <= TGT_W'(random_fraction) *
                                                     TGT_W'(total_reg);
                                    lo_reg        <= '0;
                                    hi_reg        <= IDX_W'(count_reg - CNT_W'(1));
                                    state_reg     <= S_ISSUE;
                                end
                            end
                            OP_CLEAR:
                            begin
                                selected_index_reg <= '0;
                                status_reg         <= ST_OK;
                                out_valid_reg      <= 1'b1;
                                count_reg          <= '0;
                                total_reg          <= '0;
                            end
                            default:
                            begin
                                selected_index_reg <= '0;
                                status_reg         <= ST_OK;
                                out_valid_reg      <= 1'b1;
                            end
                        endcase
                    end
                    else if (out_valid_reg && !out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_ISSUE:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid_issue;
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        selected_index_reg <= INDEX_W'(lo_reg);
                        out_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                S_CMP:
                begin
                    lo_reg <= lo_next;
                    hi_reg <= hi_next;
                    if (lo_next < hi_next)
                    begin
                        mid_reg <= mid_next;
                    end
                    else
                    begin
                        selected_index_reg <= INDEX_W'(lo_next);
                        out_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign selected_index = selected_index_reg;
    assign status         = status_reg;

endmodule

[hw/rtl/rws_ram.sv]
module rws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/rws_checker.sv]
`include "roulette_wheel_selector_top_defines.svh"

module rws_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [rws_pkg::OP_W-1:0]     op,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [rws_pkg::INDEX_W-1:0]  selected_index,
    input logic [rws_pkg::STATUS_W-1:0] status
);

    import rws_pkg::*;

    // non-draw transactions have out_valid in the next cycle
    `RWS_ASSERT_NEXT(a_fast_result, in_valid && !in_stall && op != OP_DRAW, out_valid, "load or clear result missing")

    // a waiting result blocks new input
    `RWS_ASSERT_SAME(a_stall_back, out_valid && out_stall, in_stall, "input taken while result stalled")

    `RWS_ASSERT_SAME(a_err_index, out_valid && status != ST_OK, selected_index == '0, "nonzero index on error status")

    `RWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(selected_index) && $stable(status), "stalled result changed")

endmodule

bind roulette_wheel_selector_top rws_checker u_rws_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rws_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam bit FIXED = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLDOFF_AFTER = 400;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [INDEX_W-1:0]  idx;
        logic [STATUS_W-1:0] st;
    } selection_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [FIT_IN_W-1:0] fit;
        logic [FRAC_W-1:0]   frac;
        logic                typed_exp;
        selection_t          want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     op;
    logic [FIT_IN_W-1:0] fitness;
    logic [FRAC_W-1:0]   random_fraction;
    logic                out_valid;
    logic                out_stall;
    logic [INDEX_W-1:0]  selected_index;
    logic [STATUS_W-1:0] status;

    // wheel state mirror
    logic [SUM_W-1:0] cum_sums [MAX_ENTRIES];
    logic [CNT_W-1:0] loaded_count;
    logic [SUM_W-1:0] fitness_sum;

    selection_t pending_selections[$];
    selection_t head_sel;
    int         fail_count;
    int         accepted_in;
    int         burst_left;
    bit         gaps_on;
    bit         holdoff_done;

    roulette_wheel_selector_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .fitness         (fitness),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .selected_index  (selected_index),
        .status          (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic stim_row_t mk_row(input logic [OP_W-1:0] o,
                                         input logic [FIT_IN_W-1:0] f,
                                         input logic [FRAC_W-1:0] r,
                                         input bit typed_exp,
                                         input logic [INDEX_W-1:0] idx,
                                         input logic [STATUS_W-1:0] st);
        stim_row_t row;
        begin
            row.op = o;
            row.fit = f;
            row.frac = r;
            row.typed_exp = typed_exp;
            row.want.idx = idx;
            row.want.st = st;
            return row;
        end
    endfunction

    function automatic logic [FIT_IN_W-1:0] pick_fitness(input bit zero_heavy);
        logic [FIT_IN_W-1:0] f;
        begin
            f = FIT_IN_W'($urandom);
            if (zero_heavy && $urandom_range(0, 1) == 0)
                f = '0;
            else
                case ($urandom_range(0, 7))
                    0: f = '0;
                    1: f = '1;
                    2: f = FIT_IN_W'($urandom_range(0, 15));
                    default: ;
                endcase
            return f;
        end
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        logic [FRAC_W-1:0] r;
        begin
            r = FRAC_W'($urandom);
            case ($urandom_range(0, 7))
                0: r = '0;
                1: r = '1;
                2: r = FRAC_W'($urandom_range(0, 3));
                3: r = FRAC_W'($urandom_range(65500, 65535));
                default: ;
            endcase
            return r;
        end
    endfunction

    // first index whose cumulative sum * 2^16 reaches r * total
    task automatic predict_selection(input logic [OP_W-1:0] o,
                                     input logic [FIT_IN_W-1:0] f,
                                     input logic [FRAC_W-1:0] r,
                                     output selection_t res);
        logic [SUM_W-1:0] fit_wide;
        logic [TGT_W-1:0] r_wide;
        logic [TGT_W-1:0] total_wide;
        logic [TGT_W-1:0] target;
        int lo;
        int hi;
        int mid;
        begin
            res.idx = '0;
            res.st = ST_OK;
            if (o == OP_LOAD)
            begin
                if (loaded_count >= MAX_ENTRIES)
                    res.st = ST_FULL;
                else
                begin
                    fit_wide = SUM_W'(f);
                    fitness_sum = fitness_sum + fit_wide;
                    cum_sums[loaded_count] = fitness_sum;
                    loaded_count = loaded_count + CNT_W'(1);
                end
            end
            else if (o == OP_DRAW)
            begin
                if (loaded_count == 0 || fitness_sum == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    r_wide = TGT_W'(r);
                    total_wide = TGT_W'(fitness_sum);
                    target = r_wide * total_wide;
                    lo = 0;
                    hi = int'(loaded_count) - 1;
                    while (lo < hi)
                    begin
                        mid = lo + ((hi - lo) >> 1);
                        if ({cum_sums[mid], {FRAC_W{1'b0}}} >= target)
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    res.idx = INDEX_W'(lo);
                end
            end
            else if (o == OP_CLEAR)
            begin
                loaded_count = '0;
                fitness_sum = '0;
            end
        end
    endtask

    task automatic send_txn(input stim_row_t row);
        selection_t pred;
        int gap;
        begin
            in_valid <= 1'b1;
            op <= row.op;
            fitness <= row.fit;
            random_fraction <= row.frac;
            do @(posedge clk); while (in_stall !== 1'b0);
            predict_selection(row.op, row.fit, row.frac, pred);
            pending_selections.insert(pending_selections.size(),
                                      row.typed_exp ? row.want : pred);
            if (row.op != OP_UNUSED)
                accepted_in++;
            @(negedge clk);
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 8);
                if (gaps_on && gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_selections.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("mismatch: unexpected transaction index=%0d status=%0d",
                             selected_index, status);
            end
            else
            begin
                head_sel = pending_selections.pop_front();
                if (selected_index !== head_sel.idx || status !== head_sel.st)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch at %0t: index exp %0d got %0d, status exp %0d got %0d",
                                 $realtime, head_sel.idx, selected_index,
                                 head_sel.st, status);
                end
            end
        end
    end

    // receiver: stall density changes per segment, one long hold-off
    initial
    begin
        int seg_left;
        int stall_pct;
        seg_left = 0;
        stall_pct = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && accepted_in >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            seg_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        stim_row_t directed[$];
        int i;
        int k;
        int n_loads;
        int n_draws;
        int seq_no;
        bit fill_table;
        bit zero_heavy;

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_LOAD;
        fitness = '0;
        random_fraction = '0;
        loaded_count = '0;
        fitness_sum = '0;
        fail_count = 0;
        accepted_in = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        holdoff_done = 1'b0;

        directed = {directed, mk_row(OP_DRAW,   16'h0000, 16'h0000, FIXED, 8'd0, ST_EMPTY)};
        directed = {directed, mk_row(OP_UNUSED, 16'h0000, 16'h0000, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_LOAD,   16'h0000, 16'hFFFF, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'hFFFF, 16'd12345, FIXED, 8'd0, ST_EMPTY)};
        directed = {directed, mk_row(OP_LOAD,   16'h0000, 16'h0000, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_LOAD,   16'hFFFF, 16'h0000, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'h0000, 16'h0000, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'h0000, 16'hFFFF, PREDICTED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'h0000, 16'h8000, PREDICTED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_LOAD,   16'h0001, 16'h0000, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_LOAD,   16'hFFFF, 16'h0000, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'h0000, 16'h8000, PREDICTED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'h0000, 16'h0001, PREDICTED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_CLEAR,  16'h0000, 16'h0000, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'h0000, 16'd100, FIXED, 8'd0, ST_EMPTY)};
        directed = {directed, mk_row(OP_LOAD,   16'hAAAA, 16'h5555, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_LOAD,   16'h5555, 16'hAAAA, FIXED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'hAAAA, 16'h5555, PREDICTED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_DRAW,   16'h5555, 16'hAAAA, PREDICTED, 8'd0, ST_OK)};
        directed = {directed, mk_row(OP_CLEAR,  16'hFFFF, 16'hFFFF, FIXED, 8'd0, ST_OK)};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed.size(); i++)
            send_txn(directed[i]);

        // random: clear (most sequences), load, then draw, with some noise mixed in
        seq_no = 0;
        while (accepted_in < RANDOM_ITEMS)
        begin
            seq_no++;
            fill_table = (seq_no == 3) || ($urandom_range(0, 59) == 0);
            zero_heavy = ($urandom_range(0, 4) == 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (fill_table || $urandom_range(0, 3) != 0)
                send_txn(mk_row(OP_CLEAR, FIT_IN_W'($urandom), FRAC_W'($urandom),
                                PREDICTED, 8'd0, ST_OK));
            n_loads = fill_table ? MAX_ENTRIES + $urandom_range(1, 3) : $urandom_range(0, 24);
            for (k = 0; k < n_loads; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_txn(mk_row(OP_W'($urandom_range(0, 3)), FIT_IN_W'($urandom),
                                    FRAC_W'($urandom), PREDICTED, 8'd0, ST_OK));
                send_txn(mk_row(OP_LOAD, pick_fitness(zero_heavy), FRAC_W'($urandom),
                                PREDICTED, 8'd0, ST_OK));
            end
            n_draws = $urandom_range(1, fill_table ? 24 : 10);
            for (k = 0; k < n_draws; k++)
                send_txn(mk_row(OP_DRAW, FIT_IN_W'($urandom), pick_fraction(),
                                PREDICTED, 8'd0, ST_OK));
        end

        in_valid <= 1'b0;
        while (pending_selections.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
